FILE: rtl/core/utf8d_pkg.sv
// shared types, constants and lead byte classification for the utf-8 decoder
package utf8d_pkg;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_CP_LEN2    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_LEN3    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_LEN4    = 21'h010000;

  // sequence length announced by a lead byte
  typedef enum logic [2:0] {
    LEAD_BAD = 3'd0,
    LEAD_1   = 3'd1,
    LEAD_2   = 3'd2,
    LEAD_3   = 3'd3,
    LEAD_4   = 3'd4
  } lead_t;

  // one queue entry: everything one byte produces
  typedef struct packed {
    logic            brk;      // replacement for a broken sequence goes first
    logic            main_vld; // a second, ordinary result follows
    logic [CP_W-1:0] cp;
    logic            rep;
    logic            fin;
  } qent_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic  vld;
    qent_t ent;
  } qhead_t;

  function automatic lead_t lead_class(input logic [7:0] b);
    lead_t c;
    if (b[7:3] == 5'b11110) c = LEAD_4;
    else if (b[7:4] == 4'b1110) c = LEAD_3;
    else if (b[7:5] == 3'b110) c = LEAD_2;
    else if (b[7] == 1'b0) c = LEAD_1;
    else c = LEAD_BAD;
    return c;
  endfunction

endpackage

FILE: rtl/core/utf8d_if.sv
// byte and code point stream interfaces of the utf-8 decoder
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_end;

  modport source (output valid, output data_byte, output string_end, input ready);
  modport sink (input valid, input data_byte, input string_end, output ready);
endinterface

interface utf8d_cp_if;
  logic                        valid;
  logic                        ready;
  logic [utf8d_pkg::CP_W-1:0]  code_point;
  logic                        replaced;
  logic                        last_for_byte;
  logic                        final_of_string;

  modport source (output valid, output code_point, output replaced,
                  output last_for_byte, output final_of_string, input ready);
  modport sink (input valid, input code_point, input replaced,
                input last_for_byte, input final_of_string, output ready);
endinterface

FILE: rtl/core/utf8d_front.sv
// front end: takes bytes, tracks the open sequence and builds queue entries
module utf8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              string_end,
  output logic              push,
  output utf8d_pkg::qent_t  push_ent
);

  logic [1:0]                 rem_r, rem_nxt;
  logic [2:0]                 len_r, len_nxt;
  logic [utf8d_pkg::CP_W-1:0] part_r, part_nxt;

  logic                       is_cont;
  utf8d_pkg::lead_t           lc;
  logic [utf8d_pkg::CP_W-1:0] gathered;
  logic [utf8d_pkg::CP_W-1:0] min_cp;
  logic                       do_lead;

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign lc      = utf8d_pkg::lead_class(data_byte);

  // continuation bits placed by how many bytes are still due
  always_comb begin
    case (rem_r)
      2'd3:    gathered = part_r | {3'd0, data_byte[5:0], 12'd0};
      2'd2:    gathered = part_r | {9'd0, data_byte[5:0], 6'd0};
      2'd1:    gathered = part_r | {15'd0, data_byte[5:0]};
      default: gathered = part_r;
    endcase
  end

  always_comb begin
    case (len_r)
      3'd2:    min_cp = utf8d_pkg::MIN_CP_LEN2;
      3'd3:    min_cp = utf8d_pkg::MIN_CP_LEN3;
      3'd4:    min_cp = utf8d_pkg::MIN_CP_LEN4;
      default: min_cp = '0;
    endcase
  end

  always_comb begin
    rem_nxt           = rem_r;
    len_nxt           = len_r;
    part_nxt          = part_r;
    push_ent.brk      = 1'b0;
    push_ent.main_vld = 1'b0;
    push_ent.cp       = utf8d_pkg::REPLACEMENT_CP;
    push_ent.rep      = 1'b1;
    push_ent.fin      = string_end;
    do_lead           = 1'b0;

    if (rem_r == 2'd0) begin
      do_lead = 1'b1;
    end else if (is_cont) begin
      part_nxt = gathered;
      rem_nxt  = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        push_ent.main_vld = 1'b1;
        rem_nxt           = '0;
        len_nxt           = '0;
        if (gathered >= min_cp) begin
          push_ent.cp  = gathered;
          push_ent.rep = 1'b0;
        end
      end else if (string_end) begin
        // truncated at string end
        push_ent.main_vld = 1'b1;
        rem_nxt           = '0;
        len_nxt           = '0;
      end
    end else begin
      // sequence broken by a non-continuation byte
      push_ent.brk = 1'b1;
      rem_nxt      = '0;
      len_nxt      = '0;
      do_lead      = 1'b1;
    end

    if (do_lead) begin
      case (lc)
        utf8d_pkg::LEAD_1: begin
          push_ent.main_vld = 1'b1;
          push_ent.cp       = {13'd0, data_byte};
          push_ent.rep      = 1'b0;
        end
        utf8d_pkg::LEAD_2: begin
          part_nxt = {10'd0, data_byte[4:0], 6'd0};
          rem_nxt  = 2'd1;
          len_nxt  = 3'd2;
        end
        utf8d_pkg::LEAD_3: begin
          part_nxt = {5'd0, data_byte[3:0], 12'd0};
          rem_nxt  = 2'd2;
          len_nxt  = 3'd3;
        end
        utf8d_pkg::LEAD_4: begin
          part_nxt = {data_byte[2:0], 18'd0};
          rem_nxt  = 2'd3;
          len_nxt  = 3'd4;
        end
        default: begin
          push_ent.main_vld = 1'b1;
        end
      endcase
      if (lc != utf8d_pkg::LEAD_1 && lc != utf8d_pkg::LEAD_BAD && string_end) begin
        push_ent.main_vld = 1'b1;
        rem_nxt           = '0;
        len_nxt           = '0;
      end
    end
  end

  assign push = accept && (push_ent.brk || push_ent.main_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      len_r <= '0;
    end else if (accept) begin
      rem_r <= rem_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      part_r <= part_nxt;
    end
  end

endmodule

FILE: rtl/core/utf8d_queue.sv
// short register queue between the front and back ends
module utf8d_queue #(
  parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utf8d_pkg::qent_t  push_ent,
  input  logic              pop,
  output logic              full,
  output utf8d_pkg::qhead_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8d_pkg::qent_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign head.vld = (cnt_r != '0);
  assign head.ent = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ent;
  end

endmodule

FILE: rtl/core/utf8d_back.sv
// back end: splits queue entries into results and holds the output register
module utf8d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  utf8d_pkg::qhead_t          head,
  output logic                       pop,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [utf8d_pkg::CP_W-1:0] out_cp,
  output logic                       out_rep,
  output logic                       out_last,
  output logic                       out_fin
);

  logic                       vld_r;
  logic [utf8d_pkg::CP_W-1:0] cp_r;
  logic                       rep_r, last_r, fin_r;
  logic                       brk_sent_r;
  logic                       load, send_brk;

  assign load     = head.vld && (!vld_r || out_ready);
  assign send_brk = head.ent.brk && !brk_sent_r;
  // leave the entry in place while its second result is still due
  assign pop      = load && !(send_brk && head.ent.main_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      brk_sent_r <= 1'b0;
    end else begin
      if (load) vld_r <= 1'b1;
      else if (out_ready) vld_r <= 1'b0;
      if (load) brk_sent_r <= send_brk && head.ent.main_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_brk) begin
        cp_r   <= utf8d_pkg::REPLACEMENT_CP;
        rep_r  <= 1'b1;
        last_r <= 1'b0;
        fin_r  <= 1'b0;
      end else begin
        cp_r   <= head.ent.cp;
        rep_r  <= head.ent.rep;
        last_r <= 1'b1;
        fin_r  <= head.ent.fin;
      end
    end
  end

  assign out_valid = vld_r;
  assign out_cp    = cp_r;
  assign out_rep   = rep_r;
  assign out_last  = last_r;
  assign out_fin   = fin_r;

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
// top level of the streaming utf-8 to code point decoder
// Decodes one byte per clock cycle into code points. The front end accepts a
// beat whenever the queue has room, so a steady stream runs at one byte per
// cycle; a result passes through a queue entry and then the output register. A
// byte that breaks an open sequence and also stands alone makes two result
// beats, which leave the output port one after the other; the queue of
// QUEUE_DEPTH entries absorbs these and output stalls, and the input stalls
// only once it is full. Malformed input (bad lead, stray continuation, broken,
// truncated or overlong sequence) yields U+FFFD with replaced set.
module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  utf8d_byte_if.sink  in_byte,
  utf8d_cp_if.source  out_cp
);

  logic              q_full;
  logic              accept;
  logic              push, pop;
  utf8d_pkg::qent_t  push_ent;
  utf8d_pkg::qhead_t head;

  // input beat taken whenever the queue can hold what it makes
  assign in_byte.ready = !q_full;
  assign accept        = in_byte.valid && !q_full;

  // front: sequence tracking and classification
  utf8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_byte.data_byte),
    .string_end (in_byte.string_end),
    .push       (push),
    .push_ent   (push_ent)
  );

  // queue decouples input stalls from output stalls
  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // back: one result beat per cycle into the output register, unless the output stalls
  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_ready (out_cp.ready),
    .out_valid (out_cp.valid),
    .out_cp    (out_cp.code_point),
    .out_rep   (out_cp.replaced),
    .out_last  (out_cp.last_for_byte),
    .out_fin   (out_cp.final_of_string)
  );

  // a result that is not the last of its byte is always the broken-sequence mark
  a_first_is_replacement : assert property (@(posedge clk) disable iff (!rst_n)
    out_cp.valid && !out_cp.last_for_byte |->
      out_cp.replaced && out_cp.code_point == utf8d_pkg::REPLACEMENT_CP)
    else $error("non-final result of a byte is not a replacement");

  // the end of a string is only ever flagged on a byte's final result
  a_fin_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_cp.valid && out_cp.final_of_string |-> out_cp.last_for_byte)
    else $error("string end flagged on a non-final result");

  // the replaced flag always goes with the replacement character
  a_replaced_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_cp.valid && out_cp.replaced |-> out_cp.code_point == utf8d_pkg::REPLACEMENT_CP)
    else $error("replaced result without the replacement character");

  // no entry taken from an empty queue
  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.vld)
    else $error("queue popped while empty");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the streaming utf-8 to code point decoder
module tb_top;

  // one result beat as the checker sees it
  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0] cp;
    logic                       rep;
    logic                       last;
    logic                       fin;
  } cp_beat_t;

  // a stimulus row: the byte, its end flag and, for rows whose outcome is
  // obvious, the beats typed in by hand; the rest go through the predictor
  typedef struct packed {
    logic [7:0] b;
    logic       se;
    logic [1:0] n_typed;
    cp_beat_t   e0;
    cp_beat_t   e1;
  } stim_row_t;

  localparam logic [1:0] BY_MODEL     = 2'd3;
  localparam int         RAND_ITEMS   = 800;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         MAX_REPORTS  = 10;

  // receiver hold-off and the quiet stretch where neither side idles
  localparam int HOLD_START  = 400;
  localparam int HOLD_LEN    = 80;
  localparam int QUIET_START = 600;
  localparam int QUIET_END   = 900;

  localparam cp_beat_t NO_BEAT = '0;
  // replacement mid-string, at string end, and for a broken sequence, which
  // is not flagged as the last beat of its byte
  localparam cp_beat_t REP_MID = '{utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1, 1'b0};
  localparam cp_beat_t REP_END = '{utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1, 1'b1};
  localparam cp_beat_t REP_BRK = '{utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b0, 1'b0};

  localparam int DIR_N = 26;
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    // single byte extremes
    '{8'h00, 1'b0, 2'd1, '{21'h000000, 1'b0, 1'b1, 1'b0}, NO_BEAT},
    '{8'h7F, 1'b1, 2'd1, '{21'h00007F, 1'b0, 1'b1, 1'b1}, NO_BEAT},
    // two byte: smallest legal value, then largest
    '{8'hC2, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h80, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    '{8'hDF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hBF, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    // three byte: smallest legal value
    '{8'hE0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hA0, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    '{8'h80, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    // four byte with an f7 lead: top of the 21-bit range
    '{8'hF7, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hBF, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    '{8'hBF, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    '{8'hBF, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    // four byte overlong form of u+ffff
    '{8'hF0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h8F, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    '{8'hBF, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    '{8'hBF, 1'b0, BY_MODEL, NO_BEAT, NO_BEAT},
    // invalid lead, then a stray continuation
    '{8'hFF, 1'b0, 2'd1, REP_MID, NO_BEAT},
    '{8'h80, 1'b0, 2'd1, REP_MID, NO_BEAT},
    // sequence broken by an ascii byte: two beats from one byte
    '{8'hE2, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h41, 1'b0, 2'd2, REP_BRK, '{21'h000041, 1'b0, 1'b1, 1'b0}},
    // sequence broken by a new lead, which is then truncated at string end
    '{8'hC3, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hE1, 1'b0, 2'd1, REP_BRK, NO_BEAT},
    '{8'h82, 1'b1, 2'd1, REP_END, NO_BEAT},
    // lead on the last byte of a string, stray continuation at string end
    '{8'hC2, 1'b1, 2'd1, REP_END, NO_BEAT},
    '{8'h80, 1'b1, 2'd1, REP_END, NO_BEAT}
  };

  logic clk = 1'b0;
  logic rst_n;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_stream_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_byte(byte_ch.sink),
    .out_cp (cp_ch.source)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: mirrors the open sequence inside the decoder
  // ---------------------------------------------------------------------------
  logic [1:0]                 seq_left = '0;                   // continuation bytes still owed
  logic [utf8d_pkg::CP_W-1:0] seq_acc  = '0;                   // value bits gathered so far
  utf8d_pkg::lead_t           seq_len  = utf8d_pkg::LEAD_BAD;  // length announced by the lead

  stim_row_t feed_q[$];        // every byte to be sent, in order
  cp_beat_t  cp_exp_q[$];      // code point beats still owed by the decoder

  int feed_idx   = 0;          // next row to put on the bus
  int acc_idx    = 0;          // rows accepted so far
  int mismatches = 0;
  int beats_seen = 0;
  int rep_seen   = 0;
  int pair_bytes = 0;          // bytes that produced two beats

  function automatic utf8d_pkg::lead_t classify_lead(input logic [7:0] b);
    casez (b)
      8'b0???????: return utf8d_pkg::LEAD_1;
      8'b110?????: return utf8d_pkg::LEAD_2;
      8'b1110????: return utf8d_pkg::LEAD_3;
      8'b11110???: return utf8d_pkg::LEAD_4;
      default:     return utf8d_pkg::LEAD_BAD;
    endcase
  endfunction

  function automatic logic [utf8d_pkg::CP_W-1:0] min_for(input utf8d_pkg::lead_t len);
    case (len)
      utf8d_pkg::LEAD_2: return utf8d_pkg::MIN_CP_LEN2;
      utf8d_pkg::LEAD_3: return utf8d_pkg::MIN_CP_LEN3;
      utf8d_pkg::LEAD_4: return utf8d_pkg::MIN_CP_LEN4;
      default:           return '0;
    endcase
  endfunction

  task automatic clear_seq();
    seq_left = '0;
    seq_acc  = '0;
    seq_len  = utf8d_pkg::LEAD_BAD;
  endtask

  // byte taken as the start of a character, no sequence open
  task automatic open_lead(input logic [7:0] b, input logic se);
    utf8d_pkg::lead_t len;
    len = classify_lead(b);
    case (len)
      utf8d_pkg::LEAD_1: begin
        cp_exp_q.push_back('{{14'd0, b[6:0]}, 1'b0, 1'b1, se});
      end
      utf8d_pkg::LEAD_BAD: begin
        cp_exp_q.push_back('{utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1, se});
      end
      default: begin
        case (len)
          utf8d_pkg::LEAD_2: seq_acc = {10'd0, b[4:0], 6'd0};
          utf8d_pkg::LEAD_3: seq_acc = {5'd0, b[3:0], 12'd0};
          default:           seq_acc = {b[2:0], 18'd0};
        endcase
        seq_len  = len;
        seq_left = 2'(int'(len) - 1);
        // string ends before the sequence could complete
        if (se) begin
          clear_seq();
          cp_exp_q.push_back(REP_END);
        end
      end
    endcase
  endtask

  // works out the beats owed for one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic se);
    int n0;
    logic [utf8d_pkg::CP_W-1:0] full;
    n0 = cp_exp_q.size();
    if (seq_left == 2'd0) begin
      open_lead(b, se);
    end else if (b[7:6] == 2'b10) begin
      seq_acc  = seq_acc | (utf8d_pkg::CP_W'(b[5:0]) << (6 * (int'(seq_left) - 1)));
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        full = seq_acc;
        // overlong forms are replaced
        if (full < min_for(seq_len))
          cp_exp_q.push_back('{utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1, se});
        else cp_exp_q.push_back('{full, 1'b0, 1'b1, se});
        clear_seq();
      end else if (se) begin
        clear_seq();
        cp_exp_q.push_back(REP_END);
      end
    end else begin
      // interrupted: replace the open sequence, then start over on this byte
      clear_seq();
      cp_exp_q.push_back(REP_BRK);
      open_lead(b, se);
    end
    if (cp_exp_q.size() - n0 == 2) pair_bytes++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic se);
    feed_q.push_back('{b, se, BY_MODEL, NO_BEAT, NO_BEAT});
  endtask

  // encodes cp in len bytes, sends only the first cut of them, and flags
  // the last byte sent as string end when se is set
  task automatic push_char(input logic [utf8d_pkg::CP_W-1:0] cp, input int len,
                           input int cut, input logic se);
    logic [7:0] enc [4];
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int k = 0; k < cut; k++) push_byte(enc[k], se && (k == cut - 1));
  endtask

  // ---------------------------------------------------------------------------
  // byte sender: about 30 idle cycles in a hundred, none in the quiet stretch
  // ---------------------------------------------------------------------------
  int snd_cyc;

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.valid      <= 1'b0;
      byte_ch.data_byte  <= 8'h00;
      byte_ch.string_end <= 1'b0;
      snd_cyc            <= 0;
    end else begin
      snd_cyc <= snd_cyc + 1;
      // move on only once the current beat has gone
      if (!byte_ch.valid || byte_ch.ready) begin
        if (feed_idx < feed_q.size() &&
            ((snd_cyc >= QUIET_START && snd_cyc < QUIET_END) ||
             $urandom_range(0, 99) >= 30)) begin
          byte_ch.valid      <= 1'b1;
          byte_ch.data_byte  <= feed_q[feed_idx].b;
          byte_ch.string_end <= feed_q[feed_idx].se;
          feed_idx++;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off so the decoder backs up
  // ---------------------------------------------------------------------------
  int rcv_cyc;

  always @(posedge clk) begin
    if (!rst_n) begin
      cp_ch.ready <= 1'b0;
      rcv_cyc     <= 0;
    end else begin
      rcv_cyc <= rcv_cyc + 1;
      if (rcv_cyc >= HOLD_START && rcv_cyc < HOLD_START + HOLD_LEN) cp_ch.ready <= 1'b0;
      else if (rcv_cyc >= QUIET_START && rcv_cyc < QUIET_END) cp_ch.ready <= 1'b1;
      else cp_ch.ready <= ($urandom_range(0, 99) >= 30);
    end
  end

  // ---------------------------------------------------------------------------
  // input beat monitor: feeds the predictor, or the typed beats of the row
  // ---------------------------------------------------------------------------
  stim_row_t row_now;
  int        n_before;

  always @(posedge clk) begin
    if (rst_n && byte_ch.valid && byte_ch.ready) begin
      row_now  = feed_q[acc_idx];
      acc_idx++;
      n_before = cp_exp_q.size();
      decode_byte(byte_ch.data_byte, byte_ch.string_end);
      // typed rows keep the predictor state moving but supply their own beats
      if (row_now.n_typed != BY_MODEL) begin
        while (cp_exp_q.size() > n_before) void'(cp_exp_q.pop_back());
        if (row_now.n_typed >= 2'd1) cp_exp_q.push_back(row_now.e0);
        if (row_now.n_typed == 2'd2) cp_exp_q.push_back(row_now.e1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output beat checker
  // ---------------------------------------------------------------------------
  cp_beat_t got;
  cp_beat_t want;

  always @(posedge clk) begin
    if (rst_n && cp_ch.valid && cp_ch.ready) begin
      got = '{cp_ch.code_point, cp_ch.replaced, cp_ch.last_for_byte, cp_ch.final_of_string};
      beats_seen++;
      if (got.rep) rep_seen++;
      if (cp_exp_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected beat: cp=%06h rep=%0b last=%0b fin=%0b",
                   got.cp, got.rep, got.last, got.fin);
        mismatches++;
      end else begin
        want = cp_exp_q.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch on beat %0d: expected cp=%06h rep=%0b last=%0b fin=%0b",
                     beats_seen, want.cp, want.rep, want.last, want.fin);
            $display("  got cp=%06h rep=%0b last=%0b fin=%0b",
                     got.cp, got.rep, got.last, got.fin);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    int len;
    int cut;
    logic [utf8d_pkg::CP_W-1:0] cp;
    logic end_here;

    rst_n = 1'b0;

    for (int i = 0; i < DIR_N; i++) feed_q.push_back(DIR_TAB[i]);

    // random part: mostly well-formed characters, some overlong or cut short,
    // plus raw noise bytes
    while (feed_q.size() - DIR_N < RAND_ITEMS) begin
      pick     = $urandom_range(0, 99);
      end_here = ($urandom_range(0, 5) == 0);
      if (pick < 10) begin
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        len = (pick < 40) ? 1 : (pick < 60) ? 2 : (pick < 80) ? 3 : 4;
        case (len)
          1:       cp = utf8d_pkg::CP_W'($urandom_range(0, 'h7F));
          2:       cp = utf8d_pkg::CP_W'($urandom_range('h80, 'h7FF));
          3:       cp = utf8d_pkg::CP_W'($urandom_range('h800, 'hFFFF));
          default: cp = utf8d_pkg::CP_W'($urandom_range('h10000, 'h1FFFFF));
        endcase
        // overlong: a value that would fit in fewer bytes
        if (len > 1 && $urandom_range(0, 19) == 0)
          cp = utf8d_pkg::CP_W'($urandom_range(0,
                 int'(min_for(utf8d_pkg::lead_t'(len))) - 1));
        cut = len;
        // broken: only part of the sequence is sent
        if (len > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, len - 1);
        push_char(cp, len, cut, end_here);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // sample on the falling edge, clear of the monitors
    do @(negedge clk); while (acc_idx < feed_q.size() || cp_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes (%0d directed) and %0d code point beats", acc_idx, DIR_N,
             beats_seen);
    $display("of those %0d were replacements and %0d bytes gave two beats", rep_seen,
             pair_bytes);
    if (mismatches == 0 && cp_exp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", mismatches, cp_exp_q.size());
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d of %0d bytes accepted", acc_idx, feed_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
